### src/deq_pkg.sv
// shared types and constants for the double-ended queue unit
// no dependencies; imported by every module of the block
package deq_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int MODE_W     = 4;
	localparam int STAT_W     = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_R   = 4'd0,
		MODE_PUSH_L   = 4'd1,
		MODE_POP_R    = 4'd2,
		MODE_POP_L    = 4'd3,
		MODE_PEEK_R   = 4'd4,
		MODE_PEEK_L   = 4'd5,
		MODE_CONTAINS = 4'd6,
		MODE_ERASE_1  = 4'd7,
		MODE_ERASE_N  = 4'd8,
		MODE_REVERSE  = 4'd9,
		MODE_CLEAR    = 4'd10
	} deq_mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} deq_stat_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_SCAN = 1'b1
	} deq_state_t;

	typedef enum logic [1:0] {
		SH_HOLD = 2'd0,
		SH_UP   = 2'd1,
		SH_DOWN = 2'd2
	} deq_shift_t;

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [DATA_WIDTH-1:0] value;
	} deq_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]     status;
		logic [DATA_WIDTH-1:0] data;
		logic [CNT_W-1:0]      position;
		logic [CNT_W-1:0]      removed;
		logic [CNT_W-1:0]      occupancy;
	} deq_rsp_t;

	// broadcast to every cell of the row
	typedef struct packed {
		deq_shift_t            shift;
		logic                  wr_en;
		logic [IDX_W-1:0]      wr_idx;
		logic [DATA_WIDTH-1:0] wr_data;
	} deq_cell_cmd_t;

endpackage

### src/deq_cell.sv
// one storage cell of the row: holds a word, loads a neighbor or the write bus
// depends on deq_pkg
module deq_cell (
	input  logic                           clk,
	input  logic [deq_pkg::IDX_W-1:0]      cell_idx,
	input  deq_pkg::deq_cell_cmd_t         cmd,
	input  logic [deq_pkg::DATA_WIDTH-1:0] from_lo,
	input  logic [deq_pkg::DATA_WIDTH-1:0] from_hi,
	output logic [deq_pkg::DATA_WIDTH-1:0] data
);
	import deq_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;

	// a write aimed at this cell wins over the shift
	always_ff @(posedge clk) begin
		if (cmd.wr_en && (cmd.wr_idx == cell_idx)) begin
			data_q <= cmd.wr_data;
		end else begin
			unique case (cmd.shift)
				SH_UP:   data_q <= from_lo;
				SH_DOWN: data_q <= from_hi;
				default: data_q <= data_q;
			endcase
		end
	end

	assign data = data_q;

endmodule

### src/deq_chain.sv
// row of storage cells with head and tail taps
// depends on deq_pkg and deq_cell
module deq_chain (
	input  logic                           clk,
	input  deq_pkg::deq_cell_cmd_t         cmd,
	input  logic [deq_pkg::IDX_W-1:0]      tail_idx,
	output logic [deq_pkg::DATA_WIDTH-1:0] head,
	output logic [deq_pkg::DATA_WIDTH-1:0] tail
);
	import deq_pkg::*;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] lo_bus    [CAPACITY];
	logic [DATA_WIDTH-1:0] hi_bus    [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lo_bus[i] = '0;
		end else begin : g_lo
			assign lo_bus[i] = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign hi_bus[i] = '0;
		end else begin : g_hi
			assign hi_bus[i] = cell_data[i+1];
		end

		deq_cell u_cell (
			.clk      (clk),
			.cell_idx (IDX_W'(i)),
			.cmd      (cmd),
			.from_lo  (lo_bus[i]),
			.from_hi  (hi_bus[i]),
			.data     (cell_data[i])
		);
	end

	assign head = cell_data[0];
	assign tail = cell_data[tail_idx];

endmodule

### src/double_ended_queue_unit.sv
// top level of the double-ended queue unit: control, counters and result word
// depends on deq_pkg and deq_chain
//
// Bounded double-ended queue of CAPACITY words held in a row of cells; cell 0
// is the physical head and cell count-1 the physical tail, and a reversed flag
// swaps which physical end is the logical left. Push, pop and peek at either
// end, reverse, clear and unused modes can follow each other back to back at
// one word per cycle while results are read. Contains, erase first and erase
// all rotate the row past a single comparator, one word per cycle, so they
// hold off new requests until every word has passed (an empty queue answers
// at once). A new request is taken only while the result register is empty
// or being read in the same cycle, so a result held back by rsp_ready also
// holds off the input. No clearing pass after reset.
module double_ended_queue_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  deq_pkg::deq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output deq_pkg::deq_rsp_t rsp
);
	import deq_pkg::*;

	// control state
	deq_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             rev_q, rev_d;
	logic             rsp_valid_q;
	deq_rsp_t         rsp_q;

	// scan bookkeeping
	deq_mode_t             scan_mode_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic [IDX_W-1:0]      step_q;
	logic [CNT_W-1:0]      start_cnt_q;
	logic [CNT_W-1:0]      removed_q, removed_d;
	logic [CNT_W-1:0]      pos_q, pos_d;

	deq_cell_cmd_t         cmd;
	logic [DATA_WIDTH-1:0] head, tail;
	logic [IDX_W-1:0]      tail_idx;

	logic      accept;
	logic      empty, full;
	logic      to_tail;
	logic      start_scan;
	logic      scan_last;
	logic      rsp_load;
	deq_rsp_t  rsp_d;
	deq_mode_t req_mode;

	logic [DATA_WIDTH-1:0] scan_elem;
	logic                  scan_match;
	logic                  scan_drop;

	deq_chain u_chain (
		.clk      (clk),
		.cmd      (cmd),
		.tail_idx (tail_idx),
		.head     (head),
		.tail     (tail)
	);

	assign req_ready = (state_q == FSM_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign req_mode  = deq_mode_t'(req.mode);
	assign tail_idx  = IDX_W'(cnt_q - CNT_W'(1));
	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q == CNT_W'(CAPACITY));
	// even modes address the right end; the reversed flag swaps the ends
	assign to_tail   = (!req.mode[0]) != rev_q;

	// the word leaving the logical left end during a scan
	assign scan_elem  = rev_q ? tail : head;
	assign scan_match = (scan_elem == key_q);
	assign scan_drop  = scan_match && ((scan_mode_q == MODE_ERASE_N) ||
		((scan_mode_q == MODE_ERASE_1) && (removed_q == '0)));
	assign scan_last  = (step_q == IDX_W'(start_cnt_q - CNT_W'(1)));

	assign start_scan = accept && !empty && ((req_mode == MODE_CONTAINS) ||
		(req_mode == MODE_ERASE_1) || (req_mode == MODE_ERASE_N));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (start_scan) state_d = FSM_SCAN;
			end
			FSM_SCAN: begin
				if (scan_last) state_d = FSM_IDLE;
			end
		endcase
	end

	// datapath control and result word
	always_comb begin
		cmd       = '{shift: SH_HOLD, wr_en: 1'b0, wr_idx: '0, wr_data: '0};
		cnt_d     = cnt_q;
		rev_d     = rev_q;
		removed_d = removed_q;
		pos_d     = pos_q;
		rsp_d     = '0;
		rsp_load  = 1'b0;

		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					rsp_load = !start_scan;
					unique case (req_mode)
						MODE_PUSH_R, MODE_PUSH_L: begin
							if (full) begin
								rsp_d.status = STAT_FULL;
							end else if (to_tail) begin
								cmd.wr_en   = 1'b1;
								cmd.wr_idx  = IDX_W'(cnt_q);
								cmd.wr_data = req.value;
								cnt_d       = cnt_q + CNT_W'(1);
							end else begin
								cmd.shift   = SH_UP;
								cmd.wr_en   = 1'b1;
								cmd.wr_idx  = '0;
								cmd.wr_data = req.value;
								cnt_d       = cnt_q + CNT_W'(1);
							end
						end
						MODE_POP_R, MODE_POP_L, MODE_PEEK_R, MODE_PEEK_L: begin
							if (empty) begin
								rsp_d.status = STAT_EMPTY;
							end else begin
								rsp_d.data = to_tail ? tail : head;
								if ((req_mode == MODE_POP_R) || (req_mode == MODE_POP_L)) begin
									// popping the head shifts the row down
									if (!to_tail) cmd.shift = SH_DOWN;
									cnt_d = cnt_q - CNT_W'(1);
								end
							end
						end
						MODE_CONTAINS, MODE_ERASE_1, MODE_ERASE_N: begin
							// empty queue answers at once, otherwise the scan does
							rsp_d.status = STAT_EMPTY;
						end
						MODE_REVERSE: begin
							rev_d = !rev_q;
						end
						MODE_CLEAR: begin
							cnt_d = '0;
							rev_d = 1'b0;
						end
						default: begin
						end
					endcase
					rsp_d.occupancy = cnt_d;
				end
			end
			FSM_SCAN: begin
				// rotate the row by one: the left word goes to the far end unless dropped
				if (!rev_q) begin
					cmd.shift = SH_DOWN;
					if (!scan_drop) begin
						cmd.wr_en   = 1'b1;
						cmd.wr_idx  = tail_idx;
						cmd.wr_data = scan_elem;
					end
				end else if (!scan_drop) begin
					cmd.shift   = SH_UP;
					cmd.wr_en   = 1'b1;
					cmd.wr_idx  = '0;
					cmd.wr_data = scan_elem;
				end
				if (scan_drop) begin
					cnt_d     = cnt_q - CNT_W'(1);
					removed_d = removed_q + CNT_W'(1);
				end
				// last match in left-to-right order is the first from the right
				if ((scan_mode_q == MODE_CONTAINS) && scan_match) begin
					pos_d = start_cnt_q - CNT_W'(step_q);
				end
				if (scan_last) begin
					rsp_load = 1'b1;
					if (scan_mode_q == MODE_CONTAINS) begin
						rsp_d.status   = (pos_d != '0) ? STAT_OK : STAT_EMPTY;
						rsp_d.position = pos_d;
					end else begin
						rsp_d.status  = (removed_d != '0) ? STAT_OK : STAT_EMPTY;
						rsp_d.removed = removed_d;
					end
					rsp_d.occupancy = cnt_d;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			cnt_q       <= '0;
			rev_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rev_q   <= rev_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// scan registers and result word carry no reset
	always_ff @(posedge clk) begin
		if (start_scan) begin
			scan_mode_q <= req_mode;
			key_q       <= req.value;
			step_q      <= '0;
			start_cnt_q <= cnt_q;
			removed_q   <= '0;
			pos_q       <= '0;
		end else if (state_q == FSM_SCAN) begin
			step_q    <= step_q + IDX_W'(1);
			removed_q <= removed_d;
			pos_q     <= pos_d;
		end
		if (rsp_load) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### tb/testbench.sv
// self-checking testbench for double_ended_queue_unit
// depends on deq_pkg and the unit's rtl; a shadow deque predicts every result word
// mixes directed end cases with biased random traffic and random stalls on both channels
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int SPARE_MODE_LO = MODE_CLEAR + 1;
	localparam int SPARE_MODE_HI = (1 << MODE_W) - 1;
	localparam int RANDOM_WORDS  = 1750;
	localparam int QUIET_FROM    = 1500;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int REPORT_MAX    = 10;

	// shadow of the deque in logical order, index 0 is the left end
	class deque_shadow;
		logic [DATA_WIDTH-1:0] contents[$];
		deq_rsp_t              expected_rsp[$];
		int                    errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= REPORT_MAX) begin
				$display("%0t: mismatch, %s", $time, what);
			end
		endfunction

		// apply one request word to the shadow and return the result it should give
		function deq_rsp_t predict(deq_req_t w);
			deq_rsp_t              o;
			logic [DATA_WIDTH-1:0] kept[$];
			int                    n_del;
			bit                    hit;
			bit                    right_end;
			o         = '0;
			n_del     = 0;
			hit       = 1'b0;
			right_end = (w.mode[0] == 1'b0);
			case (w.mode)
				MODE_PUSH_R, MODE_PUSH_L: begin
					if (contents.size() >= CAPACITY) begin
						o.status = STAT_FULL;
					end else if (right_end) begin
						contents.push_back(w.value);
					end else begin
						contents.push_front(w.value);
					end
				end
				MODE_POP_R, MODE_POP_L, MODE_PEEK_R, MODE_PEEK_L: begin
					if (contents.size() == 0) begin
						o.status = STAT_EMPTY;
					end else begin
						o.data = right_end ? contents[contents.size() - 1] : contents[0];
						if (w.mode == MODE_POP_R) begin
							void'(contents.pop_back());
						end else if (w.mode == MODE_POP_L) begin
							void'(contents.pop_front());
						end
					end
				end
				MODE_CONTAINS: begin
					// position counts from the right end, first hit wins
					o.status = STAT_EMPTY;
					for (int i = 0; i < contents.size(); i++) begin
						if (!hit && contents[contents.size() - 1 - i] == w.value) begin
							hit        = 1'b1;
							o.position = CNT_W'(i + 1);
							o.status   = STAT_OK;
						end
					end
				end
				MODE_ERASE_1, MODE_ERASE_N: begin
					// scan from the left end
					foreach (contents[i]) begin
						if (contents[i] == w.value && (w.mode == MODE_ERASE_N || n_del == 0)) begin
							n_del++;
						end else begin
							kept.push_back(contents[i]);
						end
					end
					contents  = kept;
					o.removed = CNT_W'(n_del);
					o.status  = (n_del != 0) ? STAT_OK : STAT_EMPTY;
				end
				MODE_REVERSE: begin
					for (int i = contents.size() - 1; i >= 0; i--) begin
						kept.push_back(contents[i]);
					end
					contents = kept;
				end
				MODE_CLEAR: begin
					contents.delete();
				end
				default: begin
				end
			endcase
			o.occupancy = CNT_W'(contents.size());
			return o;
		endfunction

		function void note_request(deq_req_t w);
			expected_rsp.push_back(predict(w));
		endfunction

		function void check_response(deq_rsp_t got);
			deq_rsp_t want;
			if (expected_rsp.size() == 0) begin
				flag($sformatf("result word %h with nothing outstanding", got));
				return;
			end
			want = expected_rsp.pop_front();
			if (got.status !== want.status)
				flag($sformatf("status expected %0d got %0d", want.status, got.status));
			if (got.data !== want.data)
				flag($sformatf("data expected %h got %h", want.data, got.data));
			if (got.position !== want.position)
				flag($sformatf("position expected %0d got %0d", want.position, got.position));
			if (got.removed !== want.removed)
				flag($sformatf("removed expected %0d got %0d", want.removed, got.removed));
			if (got.occupancy !== want.occupancy)
				flag($sformatf("occupancy expected %0d got %0d", want.occupancy, got.occupancy));
		endfunction
	endclass

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	deq_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	deq_rsp_t rsp;

	deque_shadow shadow = new();
	bit          quiet  = 1'b0;

	double_ended_queue_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one request word, maybe after an idle burst, and hold it until taken
	task automatic send_word(input logic [MODE_W-1:0] m, input logic [DATA_WIDTH-1:0] v);
		deq_req_t w;
		w.mode  = m;
		w.value = v;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		shadow.note_request(w);
	endtask

	// stop offering words until every outstanding result word is back
	task automatic hold_until_drained();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (shadow.pending() != 0 && waited < DRAIN_LIMIT);
	endtask

	// mode mix per segment: 0 fills, 1 drains, 2 searches and erases, 3 anything
	function automatic logic [MODE_W-1:0] pick_mode(int bias);
		int                roll;
		logic [MODE_W-1:0] m;
		roll = $urandom_range(0, 99);
		if (bias != 3 && roll < 2) begin
			m = MODE_CLEAR;
		end else begin
			case (bias)
				0: m = (roll < 70) ? MODE_W'($urandom_range(MODE_PUSH_R, MODE_PUSH_L))
				                   : MODE_W'($urandom_range(MODE_POP_R, MODE_REVERSE));
				1: m = (roll < 60) ? MODE_W'($urandom_range(MODE_POP_R, MODE_POP_L))
				     : (roll < 75) ? MODE_W'($urandom_range(MODE_PUSH_R, MODE_PUSH_L))
				                   : MODE_W'($urandom_range(MODE_PEEK_R, MODE_REVERSE));
				2: m = (roll < 20) ? MODE_W'($urandom_range(MODE_PUSH_R, MODE_PUSH_L))
				     : (roll < 70) ? MODE_W'($urandom_range(MODE_PEEK_R, MODE_ERASE_N))
				                   : MODE_W'($urandom_range(MODE_POP_R, MODE_REVERSE));
				default: m = MODE_W'($urandom_range(0, SPARE_MODE_HI));
			endcase
		end
		return m;
	endfunction

	// small pool of keys so searches hit and duplicates pile up
	function automatic logic [DATA_WIDTH-1:0] pick_value();
		int roll;
		logic [DATA_WIDTH-1:0] pool [6];
		pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
		         32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A};
		roll = $urandom_range(0, 99);
		if (roll < 55) return pool[$urandom_range(0, 5)];
		if (roll < 90) return $urandom();
		return 32'h1 << $urandom_range(0, DATA_WIDTH - 1);
	endfunction

	// every accepted result word is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			shadow.check_response(rsp);
		end
	end

	// receiver side: random stall bursts, long open stretches, none in the tail
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	initial begin : stimulus
		int sent;
		int seg_len;
		int bias;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque: pops, peeks, searches and erases all miss, then reverse and spare modes
		send_word(MODE_POP_R, 32'hFFFF_FFFF);
		send_word(MODE_POP_L, '0);
		send_word(MODE_PEEK_R, '0);
		send_word(MODE_PEEK_L, 32'hFFFF_FFFF);
		send_word(MODE_CONTAINS, '0);
		send_word(MODE_ERASE_1, '0);
		send_word(MODE_ERASE_N, 32'hFFFF_FFFF);
		send_word(MODE_REVERSE, '0);
		send_word(MODE_W'(SPARE_MODE_HI), 32'hFFFF_FFFF);
		send_word(MODE_W'(SPARE_MODE_LO), '0);
		// left push into an empty deque, then build [F, F, 0]
		send_word(MODE_PUSH_L, 32'hFFFF_FFFF);
		send_word(MODE_PUSH_R, '0);
		send_word(MODE_PUSH_L, 32'hFFFF_FFFF);
		send_word(MODE_CONTAINS, '0);
		send_word(MODE_CONTAINS, 32'hFFFF_FFFF);
		send_word(MODE_REVERSE, '0);
		send_word(MODE_PEEK_L, '0);
		send_word(MODE_PEEK_R, '0);
		send_word(MODE_POP_R, '0);
		send_word(MODE_PUSH_R, 32'hFFFF_FFFF);
		send_word(MODE_ERASE_N, 32'hFFFF_FFFF);
		send_word(MODE_ERASE_1, 32'h0000_0005);
		send_word(MODE_POP_L, '0);
		send_word(MODE_CLEAR, '0);
		hold_until_drained();

		// random segments, each with its own mode mix
		while (sent < RANDOM_WORDS) begin
			seg_len = $urandom_range(20, 60);
			bias    = $urandom_range(0, 3);
			for (int k = 0; k < seg_len && sent < RANDOM_WORDS; k++) begin
				send_word(pick_mode(bias), pick_value());
				sent++;
				if (sent == RANDOM_WORDS / 2) hold_until_drained();
				if (sent == QUIET_FROM) quiet = 1'b1;
			end
		end

		hold_until_drained();
		repeat (2 * CAPACITY + 4) @(posedge clk);
		if (shadow.pending() != 0) begin
			$display("%0d result words never arrived", shadow.pending());
		end
		if (shadow.errors == 0 && shadow.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog, several times the slowest correct run
	initial begin
		#5_000_000;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
